FILE: design/aled_pkg.sv
// Shared types, register codes and reset values for the addressable LED serial driver.
`default_nettype none
package aled_pkg;

	// Default frame store depth
	localparam int MAX_PIXELS_DEF = 256;

	// Bit periods in one pixel: green, red, blue bytes
	localparam logic [4:0] BITS_PER_PIXEL = 5'd24;

	// Register reset values
	localparam logic [7:0]  HIGH_TICKS_RST   = 8'd20;
	localparam logic [7:0]  LOW_TICKS_RST    = 8'd9;
	localparam logic [8:0]  PERIOD_TICKS_RST = 9'd30;
	localparam logic [16:0] PRESCALE_DIV_RST = 17'd3;
	localparam logic [8:0]  LED_COUNT_RST    = 9'd8;
	localparam logic [9:0]  RESET_SLOTS_RST  = 10'd96;

	// Clamp limits of the divider and the period
	localparam logic [16:0] DIV_MAX    = 17'd65536;
	localparam logic [8:0]  PERIOD_MAX = 9'd256;

	// Configuration register indexes
	typedef enum logic [2:0] {
		CFG_HIGH_TICKS   = 3'd0,
		CFG_LOW_TICKS    = 3'd1,
		CFG_PERIOD_TICKS = 3'd2,
		CFG_PRESCALE_DIV = 3'd3,
		CFG_LED_COUNT    = 3'd4,
		CFG_RESET_SLOTS  = 3'd5
	} cfg_reg_t;

	// Input item kinds
	typedef enum logic [1:0] {
		KIND_WRITE = 2'd0,
		KIND_START = 2'd1,
		KIND_TICK  = 2'd2
	} kind_t;

	// Pixel prefetch sequencer
	typedef enum logic [1:0] {
		FILL_IDLE,
		FILL_ISSUE,
		FILL_CAPT
	} fill_st_t;

endpackage
`default_nettype wire

FILE: design/aled_ram.sv
// Generic single-write, single-read RAM with registered read data (read-first).
`default_nettype none
module aled_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

FILE: design/addressable_led_serial_driver.sv
// Top level of the addressable LED serial driver: item stage, frame store, bit timing.
//
//  channel | signals                              | direction | transfer when
//  --------+--------------------------------------+-----------+-------------------------
//  input   | in_valid in_stall kind pixel_index   | in        | in_valid && !in_stall
//          | green red blue                       |           |
//  output  | out_valid out_stall pin_level        | out       | out_valid && !out_stall
//          | busy_res frame_done                  |           |
//  config  | cfg_valid cfg_ready cfg_index        | in        | cfg_valid && cfg_ready
//          | cfg_data                             |           |
//
// Each item passes from the input register to the result register; one item is
// taken every cycle while the result is not stalled. The frame store is a
// RAM with registered read: a frame starts from a register copy of entry zero, and
// each later pixel is prefetched after the previous load: read issue, then capture.
// Reset clears state and presets config; data registers and frame store have no reset.
// A stalled result holds the input register, which then stalls the input side.
`default_nettype none
module addressable_led_serial_driver
	import aled_pkg::*;
#(
	parameter int MAX_PIXELS = MAX_PIXELS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input items
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  kind,
	input  wire logic [7:0]  pixel_index,
	input  wire logic [7:0]  green,
	input  wire logic [7:0]  red,
	input  wire logic [7:0]  blue,
	// results
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             pin_level,
	output logic             busy_res,
	output logic             frame_done,
	// configuration writes
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [16:0] cfg_data
);

	localparam int AW   = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
	localparam int CMPW = ((AW + 1) > 9) ? (AW + 1) : 9;

	// Configuration registers
	logic [7:0]  high_ticks_q;
	logic [7:0]  low_ticks_q;
	logic [8:0]  period_ticks_q;
	logic [16:0] prescale_div_q;
	logic [8:0]  led_count_q;
	logic [9:0]  reset_slots_q;

	// Input stage
	logic        valid_s1;
	logic [1:0]  kind_s1;
	logic [7:0]  idx_s1;
	logic [23:0] pix_s1;

	// Driver state
	logic [15:0]   pre_q,   pre_n;
	logic [7:0]    phase_q, phase_n;
	logic [4:0]    bit_q,   bit_n;
	logic [AW-1:0] pos_q,   pos_n;
	logic [9:0]    latch_q, latch_n;
	logic [23:0]   shift_q, shift_n;
	logic          send_q,  send_n;
	logic          lat_q,   lat_n;

	// Prefetch of the next pixel
	logic [AW-1:0] nxt_q, nxt_n;
	logic [23:0]   pref_q;
	logic [23:0]   px0_q;
	fill_st_t      fill_st_q, fill_st_n;
	logic          cancel_q;
	logic          rd_en;
	logic          cap_en;
	logic [23:0]   rd_data;

	// Result register
	logic out_valid_q;
	logic pin_q, busy_q, done_q;

	// Step signals
	logic          go;
	logic          load;
	logic          done;
	logic          wr_en;
	logic          snoop_hit;
	logic [AW+7:0] idx_ext;
	logic [AW-1:0] waddr;
	logic [16:0]   div_eff;
	logic [8:0]    per_eff;
	logic [CMPW-1:0] cnt_eff;
	logic [16:0]   pre_inc;
	logic [8:0]    phase_inc;
	logic [4:0]    bit_inc;
	logic [CMPW-1:0] pos_inc;
	logic [CMPW-1:0] nxt_inc;
	logic [9:0]    latch_inc;
	logic [7:0]    duty;

	// Handshakes
	assign go        = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && out_valid_q && out_stall;
	assign cfg_ready = 1'b1;

	// Frame store address of the item in the input stage
	assign idx_ext = {{AW{1'b0}}, idx_s1};
	assign waddr   = idx_ext[AW-1:0];
	assign wr_en   = go && (kind_s1 == KIND_WRITE) &&
		(CMPW'(idx_s1) < CMPW'(MAX_PIXELS));
	assign snoop_hit = wr_en && (waddr == nxt_q);

	// Clamp the timing registers and the LED count to their working ranges
	always_comb begin
		if (prescale_div_q == 17'd0) begin
			div_eff = 17'd1;
		end else if (prescale_div_q > DIV_MAX) begin
			div_eff = DIV_MAX;
		end else begin
			div_eff = prescale_div_q;
		end
		if (period_ticks_q == 9'd0) begin
			per_eff = 9'd1;
		end else if (period_ticks_q > PERIOD_MAX) begin
			per_eff = PERIOD_MAX;
		end else begin
			per_eff = period_ticks_q;
		end
		if (led_count_q == 9'd0) begin
			cnt_eff = CMPW'(1);
		end else if (CMPW'(led_count_q) > CMPW'(MAX_PIXELS)) begin
			cnt_eff = CMPW'(MAX_PIXELS);
		end else begin
			cnt_eff = CMPW'(led_count_q);
		end
	end

	// Next driver state for the item in the input stage
	always_comb begin
		pre_n     = pre_q;
		phase_n   = phase_q;
		bit_n     = bit_q;
		pos_n     = pos_q;
		latch_n   = latch_q;
		shift_n   = shift_q;
		send_n    = send_q;
		lat_n     = lat_q;
		nxt_n     = nxt_q;
		load      = 1'b0;
		done      = 1'b0;
		pre_inc   = 17'(pre_q) + 17'd1;
		phase_inc = 9'(phase_q) + 9'd1;
		bit_inc   = bit_q + 5'd1;
		pos_inc   = CMPW'(pos_q) + CMPW'(1);
		nxt_inc   = pos_inc + CMPW'(1);
		latch_inc = latch_q + 10'd1;
		if (go) begin
			case (kind_t'(kind_s1))
				KIND_START: begin
					if (!send_q && !lat_q) begin
						pre_n   = 16'd0;
						phase_n = 8'd0;
						bit_n   = 5'd0;
						pos_n   = '0;
						latch_n = 10'd0;
						shift_n = px0_q;
						send_n  = 1'b1;
						load    = 1'b1;
						nxt_n   = AW'(1);
					end
				end
				KIND_TICK: begin
					if (send_q || lat_q) begin
						if (pre_inc < div_eff) begin
							pre_n = pre_inc[15:0];
						end else begin
							pre_n = 16'd0;
							if (phase_inc < per_eff) begin
								phase_n = phase_inc[7:0];
							end else begin
								phase_n = 8'd0;
								// end of one bit period
								if (send_q) begin
									shift_n = {shift_q[22:0], 1'b0};
									if (bit_inc >= BITS_PER_PIXEL) begin
										bit_n = 5'd0;
										if (pos_inc >= cnt_eff) begin
											send_n = 1'b0;
											if (reset_slots_q == 10'd0) begin
												done = 1'b1;
											end else begin
												lat_n   = 1'b1;
												latch_n = 10'd0;
											end
										end else begin
											pos_n   = pos_inc[AW-1:0];
											shift_n = pref_q;
											load    = 1'b1;
											nxt_n   = nxt_inc[AW-1:0];
										end
									end else begin
										bit_n = bit_inc;
									end
								end else if (lat_q) begin
									if (latch_inc >= reset_slots_q) begin
										lat_n   = 1'b0;
										latch_n = 10'd0;
										done    = 1'b1;
									end else begin
										latch_n = latch_inc;
									end
								end
							end
						end
					end
				end
				default: begin
				end
			endcase
		end
		duty = shift_n[23] ? high_ticks_q : low_ticks_q;
	end

	// Prefetch sequencer: next state
	always_comb begin
		case (fill_st_q)
			FILL_IDLE:  fill_st_n = load ? FILL_ISSUE : FILL_IDLE;
			FILL_ISSUE: fill_st_n = FILL_CAPT;
			FILL_CAPT:  fill_st_n = load ? FILL_ISSUE : FILL_IDLE;
			default:    fill_st_n = FILL_IDLE;
		endcase
	end

	// Prefetch sequencer: outputs
	always_comb begin
		rd_en  = 1'b0;
		cap_en = 1'b0;
		case (fill_st_q)
			FILL_ISSUE: rd_en  = 1'b1;
			FILL_CAPT:  cap_en = !cancel_q;
			default: begin
			end
		endcase
	end

	aled_ram #(
		.WIDTH(24),
		.DEPTH(MAX_PIXELS)
	) u_store (
		.clk  (clk),
		.we   (wr_en),
		.waddr(waddr),
		.wdata(pix_s1),
		.re   (rd_en),
		.raddr(nxt_q),
		.rdata(rd_data)
	);

	// Configuration register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_ticks_q   <= HIGH_TICKS_RST;
			low_ticks_q    <= LOW_TICKS_RST;
			period_ticks_q <= PERIOD_TICKS_RST;
			prescale_div_q <= PRESCALE_DIV_RST;
			led_count_q    <= LED_COUNT_RST;
			reset_slots_q  <= RESET_SLOTS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				CFG_HIGH_TICKS:   high_ticks_q   <= cfg_data[7:0];
				CFG_LOW_TICKS:    low_ticks_q    <= cfg_data[7:0];
				CFG_PERIOD_TICKS: period_ticks_q <= cfg_data[8:0];
				CFG_PRESCALE_DIV: prescale_div_q <= cfg_data;
				CFG_LED_COUNT:    led_count_q    <= cfg_data[8:0];
				CFG_RESET_SLOTS:  reset_slots_q  <= cfg_data[9:0];
				default: begin
				end
			endcase
		end
	end

	// Input stage: take a transfer, drop it once passed on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			kind_s1 <= kind;
			idx_s1  <= pixel_index;
			pix_s1  <= {green, red, blue};
		end
	end

	// Driver state and prefetch control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_q     <= 16'd0;
			phase_q   <= 8'd0;
			bit_q     <= 5'd0;
			pos_q     <= '0;
			latch_q   <= 10'd0;
			shift_q   <= 24'd0;
			send_q    <= 1'b0;
			lat_q     <= 1'b0;
			nxt_q     <= '0;
			fill_st_q <= FILL_IDLE;
			cancel_q  <= 1'b0;
		end else begin
			pre_q     <= pre_n;
			phase_q   <= phase_n;
			bit_q     <= bit_n;
			pos_q     <= pos_n;
			latch_q   <= latch_n;
			shift_q   <= shift_n;
			send_q    <= send_n;
			lat_q     <= lat_n;
			nxt_q     <= nxt_n;
			fill_st_q <= fill_st_n;
			// a write in the read cycle makes the read data stale
			cancel_q  <= rd_en && snoop_hit;
		end
	end

	// Prefetched pixel: a write to its entry wins over the read data
	always_ff @(posedge clk) begin
		if (snoop_hit) begin
			pref_q <= pix_s1;
		end else if (cap_en) begin
			pref_q <= rd_data;
		end
	end

	// Copy of entry zero: a frame start loads it without a read
	always_ff @(posedge clk) begin
		if (wr_en && (waddr == '0)) begin
			px0_q <= pix_s1;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			pin_q  <= send_n && (phase_n < duty);
			busy_q <= send_n || lat_n;
			done_q <= done;
		end
	end

	assign out_valid  = out_valid_q;
	assign pin_level  = pin_q;
	assign busy_res   = busy_q;
	assign frame_done = done_q;

`ifndef ASSERT_OFF
	// A finished frame reports idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && done_q |-> !busy_q)
		else $error("frame_done reported while busy");

	// The pin is only driven high during a frame
	a_pin_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && pin_q |-> busy_q)
		else $error("pin high while idle");

	// The input side stalls only behind a held item
	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q)
		else $error("input stalled with empty stage");

	// A prefetch read is always followed by its capture cycle
	a_fill_seq: assert property (@(posedge clk) disable iff (!arst_n)
		fill_st_q == FILL_ISSUE |=> fill_st_q == FILL_CAPT)
		else $error("prefetch read not captured");
`endif

endmodule
`default_nettype wire
